// File: hw/rtl/delta_stepping_relax_unit_assert.svh
// ----------------------------------------------------------------------------
// Delta-stepping relax unit assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef DELTA_STEPPING_RELAX_UNIT_ASSERT_SVH
`define DELTA_STEPPING_RELAX_UNIT_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define DSRU_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dsru assertion failed");

// Condition holds in the cycle after the trigger.
`define DSRU_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dsru assertion failed");

`endif

// File: hw/rtl/dsru_pkg.sv
// ----------------------------------------------------------------------------
// dsru_pkg
// Types and constants of the delta-stepping relax unit.
// ----------------------------------------------------------------------------
package dsru_pkg;

   localparam int VERT_BITS     = 12;
   localparam int VERTICES      = 1 << VERT_BITS;
   localparam int RANK_BITS     = 4;
   localparam int DIST_BITS     = 32;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [VERT_BITS-1:0] VERT_LAST = VERT_BITS'(VERTICES - 1);

   localparam logic [DIST_BITS-1:0] DIST_UNREACHED  = {DIST_BITS{1'b1}};
   localparam logic [DIST_BITS-1:0] DIST_MAX_FINITE = DIST_UNREACHED - 1'b1;
   // 0.04625 in Q8.24, rounded down
   localparam logic [DIST_BITS-1:0] BUCKET_HIGH_RESET = 32'd775946;

   localparam logic [2:0] REQ_PUSH     = 3'd0;
   localparam logic [2:0] REQ_RESPONSE = 3'd1;
   localparam logic [2:0] REQ_PULL     = 3'd2;
   localparam logic [2:0] REQ_WRITE    = 3'd3;
   localparam logic [2:0] REQ_CLEAR    = 3'd4;
   localparam logic [2:0] REQ_READ     = 3'd5;

   localparam logic [1:0] KIND_REQUEUE  = 2'd0;
   localparam logic [1:0] KIND_RESPONSE = 2'd1;
   localparam logic [1:0] KIND_READ     = 2'd2;

   localparam logic [1:0] REG_LIGHT_PHASE = 2'd0;
   localparam logic [1:0] REG_BUCKET_LOW  = 2'd1;
   localparam logic [1:0] REG_BUCKET_HIGH = 2'd2;

   typedef struct packed {
      logic [2:0]           req_type;
      logic [VERT_BITS-1:0] local_vertex;
      logic [VERT_BITS-1:0] peer_vertex;
      logic [RANK_BITS-1:0] peer_rank;
      logic [DIST_BITS-1:0] value;
      logic [DIST_BITS-1:0] peer_distance;
   } dsru_req_type;

   typedef struct packed {
      logic [1:0]           out_kind;
      logic [VERT_BITS-1:0] out_vertex;
      logic [VERT_BITS-1:0] out_parent_vertex;
      logic [RANK_BITS-1:0] out_rank;
      logic [DIST_BITS-1:0] out_distance;
   } dsru_rsp_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] distance;
      logic [RANK_BITS-1:0] parent_rank;
      logic [VERT_BITS-1:0] parent_index;
   } dsru_entry_type;

   typedef struct packed {
      logic                 light_phase;
      logic [DIST_BITS-1:0] bucket_low;
      logic [DIST_BITS-1:0] bucket_high;
   } dsru_cfg_type;

   typedef struct packed {
      logic                 entry_we;
      logic                 mark_we;
      logic [VERT_BITS-1:0] addr;
      dsru_entry_type       entry;
      logic                 mark;
   } dsru_wr_type;

endpackage

// File: hw/rtl/dsru_csr.sv
// ----------------------------------------------------------------------------
// dsru_csr
// APB register file: light phase flag and bucket window bounds.
// ----------------------------------------------------------------------------
module dsru_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dsru_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [dsru_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [dsru_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready,
   output dsru_pkg::dsru_cfg_type            cfg
);

   dsru_pkg::dsru_cfg_type cfg_ff;
   dsru_pkg::dsru_cfg_type cfg_in;
   logic                   wr_en;
   logic [1:0]             reg_idx;

   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            dsru_pkg::REG_LIGHT_PHASE: cfg_in.light_phase = csr_pwdata[0];
            dsru_pkg::REG_BUCKET_LOW:  cfg_in.bucket_low  = csr_pwdata;
            dsru_pkg::REG_BUCKET_HIGH: cfg_in.bucket_high = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         dsru_pkg::REG_LIGHT_PHASE:
            csr_prdata = {{(dsru_pkg::CSR_DATA_BITS-1){1'b0}}, cfg_ff.light_phase};
         dsru_pkg::REG_BUCKET_LOW:  csr_prdata = cfg_ff.bucket_low;
         dsru_pkg::REG_BUCKET_HIGH: csr_prdata = cfg_ff.bucket_high;
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_phase <= 1'b0;
         cfg_ff.bucket_low  <= '0;
         cfg_ff.bucket_high <= dsru_pkg::BUCKET_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hw/rtl/dsru_table.sv
// ----------------------------------------------------------------------------
// dsru_table
// Vertex table: entry memory (distance, parent) and visited mark memory.
// The mark memory is swept to zero after reset.
// ----------------------------------------------------------------------------
module dsru_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rd_en,
   input  logic [dsru_pkg::VERT_BITS-1:0]      rd_addr,
   output dsru_pkg::dsru_entry_type            rd_entry,
   output logic                                rd_mark,
   input  dsru_pkg::dsru_wr_type               wr,
   output logic                                clear_busy
);

   dsru_pkg::dsru_entry_type entry_mem [dsru_pkg::VERTICES];
   logic                     mark_mem  [dsru_pkg::VERTICES];

   dsru_pkg::dsru_entry_type      rd_entry_ff;
   logic                          rd_mark_ff;
   logic                          clr_busy_ff;
   logic                          clr_busy_in;
   logic [dsru_pkg::VERT_BITS-1:0] clr_addr_ff;
   logic [dsru_pkg::VERT_BITS-1:0] clr_addr_in;

   assign rd_entry   = rd_entry_ff;
   assign rd_mark    = rd_mark_ff;
   assign clear_busy = clr_busy_ff;

   assign clr_busy_in = clr_busy_ff && (clr_addr_ff != dsru_pkg::VERT_LAST);
   assign clr_addr_in = clr_addr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= entry_mem[rd_addr];
      end
      if (wr.entry_we) begin
         entry_mem[wr.addr] <= wr.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_mark_ff <= mark_mem[rd_addr];
      end
      if (clr_busy_ff) begin
         mark_mem[clr_addr_ff] <= 1'b0;
      end else if (wr.mark_we) begin
         mark_mem[wr.addr] <= wr.mark;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

endmodule

// File: hw/rtl/dsru_relax.sv
// ----------------------------------------------------------------------------
// dsru_relax
// Per-item update: relax compare, bucket window test, saturating sum,
// table write-back and result forming.
// ----------------------------------------------------------------------------
module dsru_relax (
   input  dsru_pkg::dsru_req_type   item,
   input  dsru_pkg::dsru_entry_type cur,
   input  logic                     cur_mark,
   input  dsru_pkg::dsru_cfg_type   cfg,
   output dsru_pkg::dsru_wr_type    wr_req,
   output logic                     has_result,
   output dsru_pkg::dsru_rsp_type   result
);

   logic                            lower;
   logic                            in_window;
   logic [dsru_pkg::DIST_BITS:0]    sum_wide;
   logic [dsru_pkg::DIST_BITS-1:0]  sum;
   logic                            send_rsp;
   dsru_pkg::dsru_entry_type        new_entry;

   assign lower = (cur.distance == dsru_pkg::DIST_UNREACHED)
               || (cur.distance > item.value);
   assign in_window = (cur.distance < cfg.bucket_high)
                   && (cur.distance >= cfg.bucket_low);
   assign sum_wide = {1'b0, cur.distance} + {1'b0, item.value};
   assign sum = (sum_wide >= {1'b0, dsru_pkg::DIST_MAX_FINITE})
              ? dsru_pkg::DIST_MAX_FINITE : sum_wide[dsru_pkg::DIST_BITS-1:0];
   assign send_rsp = in_window && (sum >= cfg.bucket_high)
                  && ((sum < item.peer_distance)
                      || (item.peer_distance == dsru_pkg::DIST_UNREACHED));

   assign new_entry.distance     = item.value;
   assign new_entry.parent_rank  = item.peer_rank;
   assign new_entry.parent_index = item.peer_vertex;

   always_comb begin
      wr_req.entry_we = 1'b0;
      wr_req.mark_we  = 1'b0;
      wr_req.addr     = item.local_vertex;
      wr_req.entry    = new_entry;
      wr_req.mark     = 1'b0;
      has_result      = 1'b0;
      result          = '0;
      result.out_vertex = item.local_vertex;
      case (item.req_type)
         dsru_pkg::REQ_PUSH: begin
            wr_req.entry_we = lower;
            if (lower && cfg.light_phase && !cur_mark
                && (item.value < cfg.bucket_high)) begin
               wr_req.mark_we  = 1'b1;
               wr_req.mark     = 1'b1;
               has_result      = 1'b1;
               result.out_kind = dsru_pkg::KIND_REQUEUE;
            end
         end
         dsru_pkg::REQ_RESPONSE: begin
            wr_req.entry_we = lower;
         end
         dsru_pkg::REQ_PULL: begin
            has_result               = send_rsp;
            result.out_kind          = dsru_pkg::KIND_RESPONSE;
            result.out_vertex        = item.peer_vertex;
            result.out_parent_vertex = item.local_vertex;
            result.out_rank          = item.peer_rank;
            result.out_distance      = sum;
         end
         dsru_pkg::REQ_WRITE: begin
            wr_req.entry_we = 1'b1;
         end
         dsru_pkg::REQ_CLEAR: begin
            wr_req.mark_we = 1'b1;
         end
         dsru_pkg::REQ_READ: begin
            has_result               = 1'b1;
            result.out_kind          = dsru_pkg::KIND_READ;
            result.out_parent_vertex = cur.parent_index;
            result.out_rank          = cur.parent_rank;
            result.out_distance      = cur.distance;
         end
         default: ;
      endcase
   end

endmodule

// File: hw/rtl/delta_stepping_relax_unit.sv
// ----------------------------------------------------------------------------
// delta_stepping_relax_unit
// Relaxation engine for delta-stepping shortest paths over a local vertex
// table, one table read-modify-write per item.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | dsru_req_type
//   rsp     | out       | rsp_valid/rsp_stall  | dsru_rsp_type
//   csr     | in        | APB psel/penable     | 32-bit registers at 4*i
//
// An item is read from the table at accept, then updated and written back in
// state EXEC from the registered read data, with req_stall high meanwhile.
// After reset the visited marks are swept to zero, also with req_stall high.
// A result waits in the output register; the write-back stalls only when a
// new result meets a full, stalled output register.
// ----------------------------------------------------------------------------
module delta_stepping_relax_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  dsru_pkg::dsru_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output dsru_pkg::dsru_rsp_type             rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dsru_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [dsru_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [dsru_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                     state_ff;
   logic                     state_in;
   dsru_pkg::dsru_req_type   item_ff;
   dsru_pkg::dsru_req_type   item_in;
   logic                     out_valid_ff;
   logic                     out_valid_in;
   dsru_pkg::dsru_rsp_type   out_data_ff;
   dsru_pkg::dsru_rsp_type   out_data_in;

   dsru_pkg::dsru_cfg_type   cfg;
   dsru_pkg::dsru_entry_type rd_entry;
   logic                     rd_mark;
   logic                     clear_busy;
   dsru_pkg::dsru_wr_type    wr_req;
   dsru_pkg::dsru_wr_type    wr;
   logic                     has_result;
   dsru_pkg::dsru_rsp_type   result;
   logic                     accept;
   logic                     finish;
   logic                     load_out;

   assign req_stall = clear_busy || (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign finish    = (state_ff == ST_EXEC)
                   && (!has_result || !out_valid_ff || !rsp_stall);
   assign load_out  = finish && has_result;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      wr          = wr_req;
      wr.entry_we = wr_req.entry_we && finish;
      wr.mark_we  = wr_req.mark_we && finish;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: if (finish) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign item_in      = accept ? req_data : item_ff;
   assign out_valid_in = load_out || (out_valid_ff && rsp_stall);
   assign out_data_in  = load_out ? result : out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      out_data_ff <= out_data_in;
   end

   dsru_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dsru_table u_table (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_addr    (req_data.local_vertex),
      .rd_entry   (rd_entry),
      .rd_mark    (rd_mark),
      .wr         (wr),
      .clear_busy (clear_busy)
   );

   dsru_relax u_relax (
      .item       (item_ff),
      .cur        (rd_entry),
      .cur_mark   (rd_mark),
      .cfg        (cfg),
      .wr_req     (wr_req),
      .has_result (has_result),
      .result     (result)
   );

endmodule

// File: hw/rtl/dsru_checker.sv
// ----------------------------------------------------------------------------
// dsru_checker
// Port-level checks of the relax unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "delta_stepping_relax_unit_assert.svh"

module dsru_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input dsru_pkg::dsru_rsp_type rsp_data
);

   logic is_requeue;
   logic requeue_zero;

   assign is_requeue   = (rsp_data.out_kind == dsru_pkg::KIND_REQUEUE);
   assign requeue_zero = (rsp_data.out_parent_vertex == '0) && (rsp_data.out_rank == '0)
                      && (rsp_data.out_distance == '0);

   `DSRU_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `DSRU_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_data))
   `DSRU_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   `DSRU_ASSERT_SAME(a_requeue_zero, rsp_valid && is_requeue, requeue_zero)
   `DSRU_ASSERT_SAME(a_clear_after_reset, $past(reset), req_stall && !rsp_valid)

endmodule

bind delta_stepping_relax_unit dsru_checker u_checker (.*);

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the delta-stepping relax unit. A queue of messages
// feeds a valid/stall driver; every accepted message is run through a local
// copy of the vertex table to predict the requeue, response or read item.
// Phases sweep the bucket window, the light phase flag and the idling modes.
// ----------------------------------------------------------------------------
module tb;

   typedef logic [dsru_pkg::DIST_BITS-1:0] dist_type;
   typedef logic [dsru_pkg::VERT_BITS-1:0] vert_type;
   typedef logic [dsru_pkg::RANK_BITS-1:0] rank_type;

   localparam int          HOT_N        = 32;
   localparam int          PHASE_ITEMS  = 225;
   localparam int          HOLD_CYCLES  = 600;
   localparam int          LIMIT_CYCLES = 300000;
   localparam int          IDLE_HEAVY   = 72;
   localparam int          IDLE_LIGHT   = 7;
   localparam logic [2:0]  REQ_UNUSED_A = 3'd6;
   localparam logic [2:0]  REQ_UNUSED_B = 3'd7;

   logic                               clock;
   logic                               reset       = 1'b1;
   logic                               req_valid   = 1'b0;
   logic                               req_stall;
   dsru_pkg::dsru_req_type             req_data    = '0;
   logic                               rsp_valid;
   logic                               rsp_stall   = 1'b0;
   dsru_pkg::dsru_rsp_type             rsp_data;
   logic                               csr_psel    = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite  = 1'b0;
   logic [dsru_pkg::CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [dsru_pkg::CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [dsru_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                               csr_pready;

   delta_stepping_relax_unit dut (.*);

   // local copy of the vertex table and bucket registers
   dist_type dist_tbl  [dsru_pkg::VERTICES];
   rank_type prank_tbl [dsru_pkg::VERTICES];
   vert_type pidx_tbl  [dsru_pkg::VERTICES];
   bit       mark_tbl  [dsru_pkg::VERTICES];
   logic     cfg_light = 1'b0;
   dist_type cfg_low   = '0;
   dist_type cfg_high  = dsru_pkg::BUCKET_HIGH_RESET;

   bit       written [dsru_pkg::VERTICES];
   vert_type written_list [$];
   vert_type hot [HOT_N];

   dsru_pkg::dsru_req_type pending_items [$];
   dsru_pkg::dsru_rsp_type expected_results [$];

   logic req_fire     = 1'b0;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   bit   pressure_on   = 1'b0;
   int   hold_cnt      = 0;
   int   mismatches    = 0;
   int   cycle_count   = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endtask

   function automatic bit relax_entry(input vert_type v, input dist_type cand,
                                      input vert_type pv, input rank_type pr);
      if (dist_tbl[v] == dsru_pkg::DIST_UNREACHED || dist_tbl[v] > cand) begin
         dist_tbl[v]  = cand;
         pidx_tbl[v]  = pv;
         prank_tbl[v] = pr;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // applies one message to the table copy; returns 1 when it yields an item
   function automatic bit apply_message(input dsru_pkg::dsru_req_type it,
                                        output dsru_pkg::dsru_rsp_type r);
      vert_type v;
      dist_type ud;
      dist_type total;
      bit       has;
      v   = it.local_vertex;
      r   = '0;
      has = 1'b0;
      case (it.req_type)
         dsru_pkg::REQ_PUSH: begin
            if (relax_entry(v, it.value, it.peer_vertex, it.peer_rank) && cfg_light
                && !mark_tbl[v] && it.value < cfg_high) begin
               mark_tbl[v]  = 1'b1;
               r.out_kind   = dsru_pkg::KIND_REQUEUE;
               r.out_vertex = v;
               has          = 1'b1;
            end
         end
         dsru_pkg::REQ_RESPONSE: begin
            void'(relax_entry(v, it.value, it.peer_vertex, it.peer_rank));
         end
         dsru_pkg::REQ_PULL: begin
            ud = dist_tbl[v];
            if (ud < cfg_high && ud >= cfg_low) begin
               if (ud >= dsru_pkg::DIST_MAX_FINITE
                   || it.value >= dsru_pkg::DIST_MAX_FINITE - ud)
                  total = dsru_pkg::DIST_MAX_FINITE;
               else
                  total = ud + it.value;
               if (total >= cfg_high
                   && (total < it.peer_distance
                       || it.peer_distance == dsru_pkg::DIST_UNREACHED)) begin
                  r.out_kind          = dsru_pkg::KIND_RESPONSE;
                  r.out_vertex        = it.peer_vertex;
                  r.out_parent_vertex = v;
                  r.out_rank          = it.peer_rank;
                  r.out_distance      = total;
                  has                 = 1'b1;
               end
            end
         end
         dsru_pkg::REQ_WRITE: begin
            dist_tbl[v]  = it.value;
            pidx_tbl[v]  = it.peer_vertex;
            prank_tbl[v] = it.peer_rank;
         end
         dsru_pkg::REQ_CLEAR: begin
            mark_tbl[v] = 1'b0;
         end
         dsru_pkg::REQ_READ: begin
            r.out_kind          = dsru_pkg::KIND_READ;
            r.out_vertex        = v;
            r.out_parent_vertex = pidx_tbl[v];
            r.out_rank          = prank_tbl[v];
            r.out_distance      = dist_tbl[v];
            has                 = 1'b1;
         end
         default: ;
      endcase
      return has;
   endfunction

   // clustered around the current bucket, with the extremes mixed in
   function automatic dist_type pick_distance();
      int       sel;
      dist_type span;
      sel  = $urandom_range(99);
      span = cfg_high - cfg_low;
      if (sel < 5)  return '0;
      if (sel < 12) return dsru_pkg::DIST_UNREACHED;
      if (sel < 16) return dsru_pkg::DIST_MAX_FINITE;
      if (sel < 30) return $urandom;
      if (sel < 75 && cfg_high > cfg_low) return cfg_low + ($urandom % span);
      if (sel < 90) return cfg_high + $urandom_range(0, 4096);
      return $urandom_range(0, 32'h00FF_FFFF);
   endfunction

   function automatic dsru_pkg::dsru_req_type mk_req(input logic [2:0] kind,
                                                     input vert_type lv,
                                                     input vert_type pv,
                                                     input rank_type pr,
                                                     input dist_type val,
                                                     input dist_type pd);
      dsru_pkg::dsru_req_type it;
      it.req_type      = kind;
      it.local_vertex  = lv;
      it.peer_vertex   = pv;
      it.peer_rank     = pr;
      it.value         = val;
      it.peer_distance = pd;
      return it;
   endfunction

   function automatic dsru_pkg::dsru_req_type make_item();
      dsru_pkg::dsru_req_type it;
      int                     sel;
      dist_type               span;
      it               = '0;
      it.peer_vertex   = vert_type'($urandom);
      it.peer_rank     = rank_type'($urandom);
      it.peer_distance = $urandom;
      sel = $urandom_range(99);
      if (sel < 30)      it.req_type = dsru_pkg::REQ_PUSH;
      else if (sel < 42) it.req_type = dsru_pkg::REQ_RESPONSE;
      else if (sel < 62) it.req_type = dsru_pkg::REQ_PULL;
      else if (sel < 77) it.req_type = dsru_pkg::REQ_WRITE;
      else if (sel < 85) it.req_type = dsru_pkg::REQ_CLEAR;
      else if (sel < 97) it.req_type = dsru_pkg::REQ_READ;
      else               it.req_type = $urandom_range(0, 1) ? REQ_UNUSED_A : REQ_UNUSED_B;
      sel = $urandom_range(99);
      if (sel < 80)
         it.local_vertex = hot[$urandom_range(HOT_N - 1)];
      else if (sel < 90 && written_list.size() != 0)
         it.local_vertex = written_list[$urandom_range(written_list.size() - 1)];
      else
         it.local_vertex = vert_type'($urandom);
      // never touch an entry before it holds a distance
      if (it.req_type != dsru_pkg::REQ_WRITE && !written[it.local_vertex])
         it.req_type = dsru_pkg::REQ_WRITE;
      case (it.req_type)
         dsru_pkg::REQ_PUSH, dsru_pkg::REQ_RESPONSE, dsru_pkg::REQ_WRITE:
            it.value = pick_distance();
         dsru_pkg::REQ_PULL: begin
            span = cfg_high - cfg_low;
            it.value = $urandom_range(0, 1) ? $urandom_range(0, span + (span >> 2))
                                            : pick_distance();
            it.peer_distance = ($urandom_range(99) < 30) ? dsru_pkg::DIST_UNREACHED
                                                         : pick_distance();
         end
         default: it.value = $urandom;
      endcase
      return it;
   endfunction

   task automatic queue_item(input dsru_pkg::dsru_req_type it);
      if (it.req_type == dsru_pkg::REQ_WRITE && !written[it.local_vertex]) begin
         written[it.local_vertex] = 1'b1;
         written_list.push_back(it.local_vertex);
      end
      pending_items.push_back(it);
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // register write followed by a read back of the same register
   task automatic csr_write(input logic [1:0] idx, input dist_type data);
      logic [dsru_pkg::CSR_DATA_BITS-1:0] want;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         dsru_pkg::REG_LIGHT_PHASE: cfg_light = data[0];
         dsru_pkg::REG_BUCKET_LOW:  cfg_low   = data;
         dsru_pkg::REG_BUCKET_HIGH: cfg_high  = data;
         default: ;
      endcase
      want = (idx == dsru_pkg::REG_LIGHT_PHASE) ? {31'b0, cfg_light}
           : (idx == dsru_pkg::REG_BUCKET_LOW) ? cfg_low : cfg_high;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want)
         flag_mismatch($sformatf("csr %0d read back: expected %h got %h",
                                 idx, want, csr_prdata));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic run_phase(input logic light, input dist_type low,
                            input dist_type high, input int idle_pct,
                            input int stall_pct, input bit hold);
      dsru_pkg::dsru_req_type it;
      int                     n;
      csr_write(dsru_pkg::REG_LIGHT_PHASE, {31'b0, light});
      csr_write(dsru_pkg::REG_BUCKET_LOW, low);
      csr_write(dsru_pkg::REG_BUCKET_HIGH, high);
      @(posedge clock);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      pressure_on   = hold;
      n = 0;
      while (n < PHASE_ITEMS) begin
         it = make_item();
         queue_item(it);
         if (it.req_type <= dsru_pkg::REQ_READ) n++;
      end
      wait_drained();
      pressure_on = 1'b0;
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      hold_cnt <= pressure_on ? hold_cnt + 1 : 0;
   end

   always @(negedge clock) begin
      rsp_stall <= (pressure_on && hold_cnt < HOLD_CYCLES)
                || ($urandom_range(99) < rsp_stall_pct);
   end

   // monitor
   always @(posedge clock) begin : monitor
      dsru_pkg::dsru_rsp_type want;
      dsru_pkg::dsru_rsp_type pred;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               flag_mismatch($sformatf({"unexpected item: kind %0d vertex %0d ",
                  "parent %0d rank %0d dist %h"},
                  rsp_data.out_kind, rsp_data.out_vertex, rsp_data.out_parent_vertex,
                  rsp_data.out_rank, rsp_data.out_distance));
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.out_kind !== want.out_kind
                   || rsp_data.out_vertex !== want.out_vertex
                   || rsp_data.out_parent_vertex !== want.out_parent_vertex
                   || rsp_data.out_rank !== want.out_rank
                   || rsp_data.out_distance !== want.out_distance)
                  flag_mismatch($sformatf({"item mismatch: expected kind %0d vertex %0d ",
                     "parent %0d rank %0d dist %h, got kind %0d vertex %0d parent %0d ",
                     "rank %0d dist %h"},
                     want.out_kind, want.out_vertex, want.out_parent_vertex, want.out_rank,
                     want.out_distance, rsp_data.out_kind, rsp_data.out_vertex,
                     rsp_data.out_parent_vertex, rsp_data.out_rank, rsp_data.out_distance));
            end
         end
         if (req_valid && !req_stall)
            if (apply_message(req_data, pred)) expected_results.push_back(pred);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      hot[0] = '0;
      hot[1] = dsru_pkg::VERT_LAST;
      for (int i = 2; i < HOT_N; i++) hot[i] = vert_type'($urandom);
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed: bucket registers at reset values
      csr_write(dsru_pkg::REG_LIGHT_PHASE, 32'd1);
      queue_item(mk_req(dsru_pkg::REQ_WRITE, '0, dsru_pkg::VERT_LAST, 4'd15,
                        32'h0000_0100, '0));
      queue_item(mk_req(dsru_pkg::REQ_WRITE, dsru_pkg::VERT_LAST, '0, '0,
                        dsru_pkg::DIST_UNREACHED, '0));
      queue_item(mk_req(dsru_pkg::REQ_READ, '0, '0, '0, '0, '0));
      queue_item(mk_req(dsru_pkg::REQ_READ, dsru_pkg::VERT_LAST, '0, '0, '0, '0));
      // unreached candidate into unreached entry
      queue_item(mk_req(dsru_pkg::REQ_PUSH, dsru_pkg::VERT_LAST, 12'd5, 4'd3,
                        dsru_pkg::DIST_UNREACHED, '0));
      queue_item(mk_req(dsru_pkg::REQ_READ, dsru_pkg::VERT_LAST, '0, '0, '0, '0));
      queue_item(mk_req(dsru_pkg::REQ_PUSH, dsru_pkg::VERT_LAST, 12'hABC, 4'd9, 32'd5, '0));
      queue_item(mk_req(dsru_pkg::REQ_PUSH, dsru_pkg::VERT_LAST, 12'd1, 4'd1, 32'd5, '0));
      queue_item(mk_req(dsru_pkg::REQ_CLEAR, dsru_pkg::VERT_LAST, '0, '0, '0, '0));
      queue_item(mk_req(dsru_pkg::REQ_PUSH, dsru_pkg::VERT_LAST, 12'd2, 4'd2, 32'd4, '0));
      queue_item(mk_req(dsru_pkg::REQ_PUSH, dsru_pkg::VERT_LAST, 12'd3, 4'd3, 32'd3, '0));
      queue_item(mk_req(dsru_pkg::REQ_PUSH, '0, 12'd4, 4'd4,
                        dsru_pkg::BUCKET_HIGH_RESET, '0));
      queue_item(mk_req(dsru_pkg::REQ_RESPONSE, '0, 12'h555, 4'd10, '0, '0));
      queue_item(mk_req(dsru_pkg::REQ_READ, '0, '0, '0, '0, '0));
      queue_item(mk_req(dsru_pkg::REQ_PULL, '0, 12'h123, 4'd7,
                        dsru_pkg::BUCKET_HIGH_RESET, dsru_pkg::DIST_UNREACHED));
      queue_item(mk_req(dsru_pkg::REQ_PULL, '0, 12'h124, 4'd6, 32'd1,
                        dsru_pkg::DIST_UNREACHED));
      // saturated sum
      queue_item(mk_req(dsru_pkg::REQ_PULL, '0, dsru_pkg::VERT_LAST, 4'd15,
                        dsru_pkg::DIST_UNREACHED, dsru_pkg::DIST_MAX_FINITE));
      queue_item(mk_req(dsru_pkg::REQ_PULL, '0, dsru_pkg::VERT_LAST, 4'd15,
                        dsru_pkg::DIST_UNREACHED, dsru_pkg::DIST_UNREACHED));
      // unreached source
      queue_item(mk_req(dsru_pkg::REQ_WRITE, 12'd7, 12'd8, 4'd8,
                        dsru_pkg::DIST_UNREACHED, '0));
      queue_item(mk_req(dsru_pkg::REQ_PULL, 12'd7, 12'd1, 4'd1, '0,
                        dsru_pkg::DIST_UNREACHED));
      queue_item(mk_req(REQ_UNUSED_A, '0, dsru_pkg::VERT_LAST, 4'd15,
                        dsru_pkg::DIST_UNREACHED, dsru_pkg::DIST_UNREACHED));
      queue_item(mk_req(REQ_UNUSED_B, dsru_pkg::VERT_LAST, '0, '0, '0, '0));
      queue_item(mk_req(dsru_pkg::REQ_READ, dsru_pkg::VERT_LAST, '0, '0, '0, '0));
      wait_drained();

      run_phase(1'b1, '0, dsru_pkg::BUCKET_HIGH_RESET, 0, 0, 1'b1);
      run_phase(1'b1, 32'h0010_0000, 32'h0040_0000, IDLE_HEAVY, 0, 1'b0);
      run_phase(1'b1, '0, dsru_pkg::DIST_UNREACHED, 0, IDLE_HEAVY, 1'b0);
      run_phase(1'b0, 32'h0008_0000, 32'h0100_0000, IDLE_LIGHT, IDLE_LIGHT, 1'b0);
      run_phase(1'b1, '0, '0, 0, 0, 1'b0);
      run_phase(1'b1, dsru_pkg::DIST_UNREACHED, dsru_pkg::DIST_UNREACHED, 0, IDLE_HEAVY,
                1'b0);
      run_phase(1'b1, 32'h0100_0000, dsru_pkg::DIST_MAX_FINITE, IDLE_HEAVY, 0, 1'b0);
      run_phase(1'b1, 32'h0001_0000, 32'h0020_0000, IDLE_LIGHT, IDLE_LIGHT, 1'b0);

      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/dsru_pkg.sv
hw/rtl/dsru_csr.sv
hw/rtl/dsru_table.sv
hw/rtl/dsru_relax.sv
hw/rtl/delta_stepping_relax_unit.sv
hw/rtl/dsru_checker.sv
sim/tb.sv
